// ----- hdl/lzrle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lzrle_pkg;
  // history window size in bytes
  localparam int unsigned HISTORY_DEPTH = 512;

  typedef enum logic [1:0] {
    OP_FEED  = 2'd0,
    OP_PULL  = 2'd1,
    OP_START = 2'd2,
    OP_BAD   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SIZE     = 2'd1,
    ST_BAD_REF  = 2'd2,
    ST_UNEXPECT = 2'd3
  } status_e;

  localparam logic [3:0] KIND_LIT   = 4'h0;
  localparam logic [3:0] KIND_DBL   = 4'h1;
  localparam logic [3:0] KIND_CPYE  = 4'h2;
  localparam logic [3:0] KIND_CPYO  = 4'h3;
  localparam logic [3:0] KIND_FILL  = 4'h4;
  localparam logic [3:0] KIND_LFILL = 4'h5;
  localparam logic [3:0] KIND_ZERO  = 4'h6;

  // result item as packed on the output
  typedef struct packed {
    logic [1:0] status;
    logic       finished;
    logic       need_byte;
    logic       out_valid;
    logic [7:0] out_byte;
  } result_t;
endpackage
`default_nettype wire

// ----- hdl/lzrle_hist_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lzrle_hist_ram #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [AddrW-1:0]  waddr_i,
  input  wire [7:0]        wdata_i,
  input  wire [AddrW-1:0]  raddr_i,
  output logic [7:0]       rdata_o
);
  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/lz_rle_token_decompressor_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       tdata: opcode[1:0], in_byte[9:2]
// m_axis    out        m_axis_tvalid/tready       tdata: out_byte, out_valid, need_byte,
//                                                 finished, status
// cfg       in         cfg_valid_i/cfg_ready_o    expected_length
//
// one item per cycle: an accepted item is decoded combinationally into the
// result register; the history read is issued in the cycle before, from state
// that is already known, and a byte written in the same cycle is forwarded.
// reset clears the decoder state; history holds no reset value.
// the input stalls only while a result sits in the output register unread.
module lz_rle_token_decompressor_top #(
  parameter int unsigned COUNT_WIDTH   = 24
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [15:0]  s_axis_tdata,   // opcode[1:0], in_byte[9:2], zeros
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // out_byte[7:0], out_valid, need_byte,
                                       // finished, status[12:11], zeros
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [23:0]  cfg_data_i      // expected_length
);
  import lzrle_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [23:0] exp_len_q;
  logic [AW-1:0] wp_q, wp_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [7:0] tok_q, tok_d, fop_q, fop_d, fill_q, fill_d;
  logic [1:0] opp_q, opp_d;
  logic [14:0] run_q, run_d;
  logic [8:0] cdist_q, cdist_d;
  logic fin_q, fin_d;
  logic [1:0] err_q, err_d;

  result_t res_q, res_d;
  logic out_v_q;

  // history
  logic we;
  logic [7:0] wdata, rdata;
  logic [AW-1:0] raddr;
  logic fwd_q;
  logic [7:0] fwd_byte_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_v_q || m_axis_tready;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b0, res_q};

  wire acc = s_axis_tvalid && s_axis_tready;
  wire [1:0] opc = s_axis_tdata[1:0];
  wire [7:0] ib  = s_axis_tdata[9:2];

  // distance for the next pull, from current state
  function automatic logic [8:0] next_dist(input logic [7:0] t, input logic [14:0] r,
                                           input logic [8:0] cd);
    logic [3:0] k;
    begin
      k = t[7:4];
      next_dist = 9'd0;
      case (k)
        KIND_DBL: next_dist = 9'(t[3:0]) + 9'd9 + ((r == 15'd1) ? 9'd1 : 9'd0);
        KIND_CPYE, KIND_CPYO: next_dist = cd;
        4'h7, 4'h8, 4'h9, 4'hA, 4'hB: next_dist = 9'(t) - 9'd103;
        4'hC, 4'hD, 4'hE, 4'hF:
          next_dist = (r >= 15'd2) ? 9'(t[5:3]) + 9'd1 : 9'(t[2:0]) + 9'd2;
        default: next_dist = 9'd0;
      endcase
    end
  endfunction

  // address issued from the state about to be registered
  logic [8:0] dist_d;
  assign dist_d = next_dist(tok_d, run_d, cdist_d);
  assign raddr  = wp_d - dist_d[AW-1:0];

  lzrle_hist_ram #(.Depth(HISTORY_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [8:0] dist_q;
  assign dist_q = next_dist(tok_q, run_q, cdist_q);
  wire [7:0] hist_byte = fwd_q ? fwd_byte_q : rdata;

  always_comb begin
    logic [3:0] kind, low;
    logic unexp, valid, ok, isfill, bnd;
    logic [7:0] prod;
    kind = tok_q[7:4];
    low = tok_q[3:0];
    wp_d = wp_q; cnt_d = cnt_q; tok_d = tok_q; fop_d = fop_q; fill_d = fill_q;
    opp_d = opp_q; run_d = run_q; cdist_d = cdist_q; fin_d = fin_q; err_d = err_q;
    unexp = 1'b0; valid = 1'b0; prod = 8'd0; we = 1'b0; bnd = 1'b0;
    ok = 1'b1; isfill = 1'b0;
    if (acc) begin
      case (opc)
        OP_START: begin
          cnt_d = '0; tok_d = '0; opp_d = '0; fop_d = '0; run_d = '0;
          cdist_d = '0; fill_d = '0; fin_d = 1'b0; err_d = ST_OK;
          bnd = 1'b1;
        end
        OP_FEED: begin
          if (fin_q || (run_q != 0 && opp_q == 0)) begin
            unexp = 1'b1;
          end else if (opp_q != 0) begin
            case (kind)
              KIND_LIT: begin fill_d = ib; opp_d = 2'd0; end
              KIND_CPYE, KIND_CPYO: begin
                cdist_d = {ib, kind[0]}; run_d = 15'(low) + 15'd3; opp_d = 2'd0;
              end
              KIND_FILL: begin fill_d = ib; run_d = 15'(low) + 15'd3; opp_d = 2'd0; end
              default: begin
                if (opp_q == 2'd2) begin
                  fop_d = ib; opp_d = 2'd1;
                end else begin
                  fill_d = ib; opp_d = 2'd0;
                  run_d = {1'b0, fop_q, low, 2'b00} + 15'd19;
                end
              end
            endcase
          end else begin
            tok_d = ib;
            bnd = 1'b1;
            if (ib == 8'd0) begin
              if (cnt_q != COUNT_WIDTH'(exp_len_q)) err_d = ST_SIZE;
              fin_d = 1'b1;
            end else begin
              case (ib[7:4])
                KIND_LIT: begin run_d = 15'(ib); opp_d = 2'd1; end
                KIND_CPYE, KIND_CPYO, KIND_FILL: opp_d = 2'd1;
                KIND_LFILL: opp_d = 2'd2;
                KIND_ZERO: begin fill_d = 8'd0; run_d = 15'(ib[3:0]) + 15'd2; end
                default: run_d = 15'd2;
              endcase
            end
          end
        end
        OP_PULL: begin
          if (fin_q || opp_q != 0 || run_q == 0) begin
            unexp = 1'b1;
          end else begin
            isfill = (kind == KIND_LIT) || (kind == KIND_FILL) ||
                     (kind == KIND_LFILL) || (kind == KIND_ZERO);
            if (isfill) begin
              prod = fill_q;
            end else if (dist_q == 9'd0 || COUNT_WIDTH'(dist_q) > cnt_q ||
                         32'(dist_q) > HISTORY_DEPTH) begin
              ok = 1'b0;
            end else begin
              prod = hist_byte;
            end
            if (ok) begin
              we = 1'b1;
              wp_d = wp_q + 1'b1;
              if (cnt_q != CountMax) cnt_d = cnt_q + 1'b1;
              valid = 1'b1;
              run_d = run_q - 15'd1;
              if (kind == KIND_LIT && run_d != 0) opp_d = 2'd1;
              bnd = 1'b1;
            end else begin
              err_d = ST_BAD_REF; fin_d = 1'b1; run_d = '0; opp_d = '0;
            end
          end
        end
        default: unexp = 1'b1;
      endcase
      // token boundary finish check
      if (bnd && run_d == 0 && opp_d == 0 && cnt_d >= COUNT_WIDTH'(exp_len_q))
        fin_d = 1'b1;
    end
    wdata = prod;
    res_d.out_byte  = valid ? prod : 8'd0;
    res_d.out_valid = valid;
    res_d.need_byte = !fin_d && (opp_d != 0 || run_d == 0);
    res_d.finished  = fin_d;
    res_d.status    = unexp ? ST_UNEXPECT : err_d;
  end

  // count compare widths: COUNT_WIDTH may be below 24, fold via cast above

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0; wp_q <= '0; cnt_q <= '0; tok_q <= '0; fop_q <= '0;
      fill_q <= '0; opp_q <= '0; run_q <= '0; cdist_q <= '0; fin_q <= 1'b0;
      err_q <= '0; out_v_q <= 1'b0; fwd_q <= 1'b0;
    end else begin
      if (cfg_valid_i) exp_len_q <= cfg_data_i;
      wp_q <= wp_d; cnt_q <= cnt_d; tok_q <= tok_d; fop_q <= fop_d;
      fill_q <= fill_d; opp_q <= opp_d; run_q <= run_d; cdist_q <= cdist_d;
      fin_q <= fin_d; err_q <= err_d;
      // forward when the next read hits the byte being written now
      fwd_q <= we && (raddr == wp_q);
      if (acc) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_byte_q <= wdata;
    if (acc) res_q <= res_d;
  end
endmodule
`default_nettype wire
